@@ hdl/bgq_pkg.sv @@
`default_nettype none
package bgq_pkg;

  localparam int BEATS_MAX = 1024;
  localparam int ADDR_W    = $clog2(BEATS_MAX);
  localparam int TIME_W    = 32;
  localparam int IDX_W     = 10;
  localparam int SUB_W     = 5;
  localparam int CNT_W     = 11;
  localparam int POS_W     = 24;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SUBDIV     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_COUNT = 1'b1;
  localparam logic [SUB_W-1:0]     SUBDIV_RESET   = 5'd4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUANT = 1'b1;

  // shared arithmetic unit widths
  localparam int OPA_W  = 50;
  localparam int OPB_W  = 34;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int STEP_W = $clog2(OPA_W);

  // beat position and wide time sums
  localparam int P_W    = 40;
  localparam int SUMT_W = 52;

  localparam logic [PROD_W-1:0] EXTRAP_LIMIT = PROD_W'(1) << 48;

  typedef enum logic {ALU_DIV, ALU_MUL} alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [OPA_W-1:0]  quo;
    logic [OPB_W-1:0]  rem;
    logic [PROD_W-1:0] prod;
  } alu_rsp_t;

  function automatic logic [TIME_W-1:0] sat_time(input logic [SUMT_W-1:0] v);
    logic [TIME_W-1:0] r;
    if (v[SUMT_W-1]) begin
      r = '0;
    end else if (v[SUMT_W-2:TIME_W] != '0) begin
      r = '1;
    end else begin
      r = v[TIME_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/bgq_if.sv @@
`default_nettype none
interface bgq_item_if;
  import bgq_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [IDX_W-1:0]  entry_index;
  logic [TIME_W-1:0] time_value;

  modport source (output valid, output func, output entry_index, output time_value,
                  input ready);
  modport sink (input valid, input func, input entry_index, input time_value,
                output ready);
endinterface

interface bgq_result_if;
  import bgq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [TIME_W-1:0]       quantized_time;
  logic signed [POS_W-1:0] grid_position;
  logic                    grid_valid;

  modport source (output valid, output quantized_time, output grid_position,
                  output grid_valid, input ready);
  modport sink (input valid, input quantized_time, input grid_position,
                input grid_valid, output ready);
endinterface
`default_nettype wire

@@ hdl/bgq_ram.sv @@
`default_nettype none
module bgq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/bgq_alu.sv @@
`default_nettype none
module bgq_alu (
  input  logic              clk,
  input  logic              rst,
  input  bgq_pkg::alu_req_t req,
  output bgq_pkg::alu_rsp_t rsp
);
  import bgq_pkg::*;

  localparam int SUM_W = OPA_W + 1;

  logic              busy;
  logic              done;
  alu_op_t           op;
  logic [STEP_W-1:0] steps;
  logic [OPA_W-1:0]  lo;
  logic [OPB_W-1:0]  den;
  logic [OPB_W-1:0]  rem;
  logic [PROD_W-1:0] prod;
  logic [OPB_W:0]    shifted;
  logic [SUM_W-1:0]  add_x;
  logic [SUM_W-1:0]  add_y;
  logic              cin;
  logic [SUM_W-1:0]  sum;
  logic              fits;

  // one adder: trial subtract for division, partial product add for multiply
  always_comb begin
    shifted = {rem, lo[OPA_W-1]};
    if (op == ALU_DIV) begin
      add_x = SUM_W'(shifted);
      add_y = ~SUM_W'(den);
      cin   = 1'b1;
    end else begin
      add_x = {1'b0, prod[PROD_W-1:OPB_W]};
      add_y = den[0] ? {1'b0, lo} : '0;
      cin   = 1'b0;
    end
    sum  = add_x + add_y + SUM_W'(cin);
    fits = ~sum[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
      op    <= ALU_DIV;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        op    <= req.op;
        lo    <= req.a;
        den   <= req.b;
        rem   <= '0;
        prod  <= '0;
        steps <= (req.op == ALU_DIV) ? STEP_W'(OPA_W - 1) : STEP_W'(OPB_W - 1);
      end else if (busy) begin
        if (op == ALU_DIV) begin
          rem <= fits ? sum[OPB_W-1:0] : shifted[OPB_W-1:0];
          lo  <= {lo[OPA_W-2:0], fits};
        end else begin
          prod <= {sum, prod[OPB_W-1:1]};
          den  <= den >> 1;
        end
        steps <= steps - STEP_W'(1);
        if (steps == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = lo;
  assign rsp.rem  = rem;
  assign rsp.prod = prod;

endmodule
`default_nettype wire

@@ hdl/beat_grid_quantizer.sv @@
// beat grid quantizer
// item channel: func selects a beat table write (entry_index, time_value) or a
// query that snaps time_value to the grid; writes produce no result, every
// query produces one transaction on the result channel.
// cfg_we/cfg_index/cfg_data set subdivisions (index 0) and beat_count (index 1);
// write them only while the block is idle.
// a query with fewer than two beats goes straight to its result. otherwise the
// first and last beats are read, a binary search finds the interval if needed,
// then up to three 50-step divisions and one 34-step multiply run on the shared
// shift/add unit; one division fewer when the interval is empty, two fewer when
// the position is before the first beat.
// the block takes one query at a time; ready is high only while no query is
// in progress. the result sits in an output register, so the next item is
// accepted while a result is still waiting; a stalled receiver holds a
// finished query only until that register frees up.
// reset sets subdivisions to 4 and beat_count to 0 and drops any pending
// result; the beat table is not cleared, entries are valid once written.
`default_nettype none
module beat_grid_quantizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bgq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bgq_pkg::CFG_W-1:0]       cfg_data,
  bgq_item_if.sink                        item,
  bgq_result_if.source                    result
);
  import bgq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_RDN, S_CHK, S_SRCH, S_SRCHW, S_RDI, S_RDI1, S_DUR, S_DIV1,
    S_MAP, S_DIVS, S_EXT, S_MULW, S_DIVE, S_RDQ, S_RDQ1, S_INTP, S_DIVI, S_DONE
  } state_t;

  localparam logic signed [P_W-1:0] POS_HI = P_W'(2 ** (POS_W - 1) - 1);
  localparam logic signed [P_W-1:0] POS_LO = -P_W'(2 ** (POS_W - 1));

  state_t                  state;
  logic [SUB_W-1:0]        subdiv;
  logic [CNT_W-1:0]        beat_count;
  logic [TIME_W-1:0]       t;
  logic [TIME_W-1:0]       b0;
  logic [TIME_W-1:0]       blast;
  logic [TIME_W-1:0]       bi;
  logic [ADDR_W-1:0]       lo;
  logic [ADDR_W-1:0]       hi;
  logic [ADDR_W-1:0]       idx_i;
  logic [ADDR_W-1:0]       qi;
  logic [SUB_W-1:0]        rr;
  logic                    neg;
  logic signed [P_W-1:0]   p;
  logic [TIME_W-1:0]       qtime;
  logic [POS_W-1:0]        gpos;
  logic                    gvalid;
  alu_req_t                alu_req;
  alu_rsp_t                alu_rsp;
  logic                    res_valid;
  logic [TIME_W-1:0]       res_time;
  logic [POS_W-1:0]        res_pos;
  logic                    res_ok;

  logic [CNT_W-1:0]        n;
  logic [SUB_W-1:0]        s;
  logic [ADDR_W-1:0]       last_idx;
  logic [ADDR_W:0]         mid_sum;
  logic [ADDR_W-1:0]       mid;
  logic                    more;
  logic [ADDR_W-1:0]       rd_addr;
  logic [TIME_W-1:0]       ram_q;
  logic                    ram_we;
  logic                    accept;
  logic                    can_load;
  logic signed [TIME_W:0]  diff;
  logic signed [TIME_W:0]  x;
  logic signed [TIME_W+6:0] xs;
  logic [TIME_W+6:0]       xs_mag;
  logic signed [TIME_W+6:0] y;
  logic [TIME_W+6:0]       y_mag;
  logic [14:0]             is_prod;
  logic [15:0]             d_val;
  logic signed [TIME_W:0]  span;
  logic [TIME_W-1:0]       span_mag;
  logic signed [P_W-1:0]   p_div;
  logic [P_W-1:0]          delta;
  logic [SUMT_W-1:0]       sum_add;
  logic [SUMT_W-1:0]       sum_sub;

  always_comb begin
    n        = (beat_count > CNT_W'(BEATS_MAX)) ? CNT_W'(BEATS_MAX) : beat_count;
    s        = (subdiv == '0) ? SUB_W'(1) : subdiv;
    last_idx = ADDR_W'(n - CNT_W'(1));
    mid_sum  = {1'b0, lo} + {1'b0, hi};
    mid      = mid_sum[ADDR_W:1];
    more     = ({1'b0, lo} + (ADDR_W+1)'(1)) < {1'b0, hi};
    accept   = item.valid && item.ready;
    can_load = !res_valid || result.ready;
    ram_we   = accept && (item.func == FUNC_WRITE) && (32'(item.entry_index) < BEATS_MAX);

    // diff is the interval width in S_DUR and the table step in S_INTP
    diff    = $signed({1'b0, ram_q}) - $signed({1'b0, bi});
    x       = $signed({1'b0, t}) - $signed({1'b0, bi});
    xs      = x * $signed({1'b0, s});
    xs_mag  = xs[TIME_W+6] ? -xs : xs;
    y       = diff * $signed({1'b0, rr});
    y_mag   = y[TIME_W+6] ? -y : y;
    is_prod = 15'(idx_i) * 15'(s);
    d_val   = 16'(s) * 16'(n - CNT_W'(1));
    span    = $signed({1'b0, blast}) - $signed({1'b0, b0});
    span_mag = span[TIME_W] ? TIME_W'(-span) : TIME_W'(span);
    p_div   = neg ? $signed(P_W'(is_prod)) - $signed(alu_rsp.quo[P_W-1:0])
                  : $signed(P_W'(is_prod)) + $signed(alu_rsp.quo[P_W-1:0]);
    delta   = P_W'(p) - P_W'(d_val);
    // blast +/- quotient for extrapolation; the interpolation sum bi +/- quotient is formed in S_DIVI
    sum_add = SUMT_W'(blast) + SUMT_W'(alu_rsp.quo);
    sum_sub = SUMT_W'(blast) - SUMT_W'(alu_rsp.quo);

    case (state)
      S_RD0:   rd_addr = '0;
      S_RDN:   rd_addr = last_idx;
      S_SRCH:  rd_addr = mid;
      S_RDI:   rd_addr = idx_i;
      S_RDI1:  rd_addr = idx_i + ADDR_W'(1);
      S_RDQ:   rd_addr = qi;
      S_RDQ1:  rd_addr = qi + ADDR_W'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      subdiv        <= SUBDIV_RESET;
      beat_count    <= '0;
      res_valid     <= 1'b0;
      alu_req.start <= 1'b0;
      alu_req.op    <= ALU_DIV;
    end else begin
      alu_req.start <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_SUBDIV:     subdiv <= cfg_data[SUB_W-1:0];
          REG_BEAT_COUNT: beat_count <= cfg_data[CNT_W-1:0];
          default:        ;
        endcase
      end

      if (state == S_DONE && can_load) begin
        res_valid <= 1'b1;
        res_time  <= qtime;
        res_pos   <= gpos;
        res_ok    <= gvalid;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && item.func == FUNC_QUANT) begin
            t <= item.time_value;
            if (n < CNT_W'(2)) begin
              qtime  <= item.time_value;
              gpos   <= '0;
              gvalid <= 1'b0;
              state  <= S_DONE;
            end else begin
              gvalid <= 1'b1;
              state  <= S_RD0;
            end
          end
        end
        S_RD0: state <= S_RDN;
        S_RDN: begin
          b0    <= ram_q;
          state <= S_CHK;
        end
        S_CHK: begin
          blast <= ram_q;
          if (t <= b0) begin
            idx_i <= '0;
            state <= S_RDI;
          end else if (t >= ram_q) begin
            idx_i <= last_idx - ADDR_W'(1);
            state <= S_RDI;
          end else begin
            lo    <= '0;
            hi    <= last_idx;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (more) begin
            state <= S_SRCHW;
          end else begin
            idx_i <= lo;
            state <= S_RDI;
          end
        end
        S_SRCHW: begin
          if (ram_q <= t) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_RDI: state <= S_RDI1;
        S_RDI1: begin
          bi    <= ram_q;
          state <= S_DUR;
        end
        S_DUR: begin
          if (!diff[TIME_W] && diff != '0) begin
            // round half away from zero: (2|x*s| + dur) / (2 dur)
            neg           <= xs[TIME_W+6];
            alu_req.start <= 1'b1;
            alu_req.op    <= ALU_DIV;
            alu_req.a     <= OPA_W'({xs_mag, 1'b0}) + OPA_W'(diff[TIME_W-1:0]);
            alu_req.b     <= OPB_W'({diff[TIME_W-1:0], 1'b0});
            state         <= S_DIV1;
          end else begin
            p     <= P_W'(is_prod);
            state <= S_MAP;
          end
        end
        S_DIV1: begin
          if (alu_rsp.done) begin
            p     <= p_div;
            state <= S_MAP;
          end
        end
        S_MAP: begin
          if (p > POS_HI) begin
            gpos <= POS_HI[POS_W-1:0];
          end else if (p < POS_LO) begin
            gpos <= POS_LO[POS_W-1:0];
          end else begin
            gpos <= p[POS_W-1:0];
          end
          if (p[P_W-1]) begin
            qtime <= b0;
            state <= S_DONE;
          end else begin
            alu_req.start <= 1'b1;
            alu_req.op    <= ALU_DIV;
            alu_req.a     <= OPA_W'(p);
            alu_req.b     <= OPB_W'(s);
            state         <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (alu_rsp.done) begin
            rr <= alu_rsp.rem[SUB_W-1:0];
            if (alu_rsp.quo >= OPA_W'(n - CNT_W'(1))) begin
              state <= S_EXT;
            end else begin
              qi    <= alu_rsp.quo[ADDR_W-1:0];
              state <= S_RDQ;
            end
          end
        end
        S_EXT: begin
          if (span == '0) begin
            qtime <= blast;
            state <= S_DONE;
          end else begin
            alu_req.start <= 1'b1;
            alu_req.op    <= ALU_MUL;
            alu_req.a     <= OPA_W'(delta);
            alu_req.b     <= OPB_W'(span_mag);
            state         <= S_MULW;
          end
        end
        S_MULW: begin
          if (alu_rsp.done) begin
            if (alu_rsp.prod > EXTRAP_LIMIT) begin
              qtime <= span[TIME_W] ? '0 : '1;
              state <= S_DONE;
            end else begin
              alu_req.start <= 1'b1;
              alu_req.op    <= ALU_DIV;
              alu_req.a     <= OPA_W'({alu_rsp.prod[48:0], 1'b0}) + OPA_W'(d_val);
              alu_req.b     <= OPB_W'({d_val, 1'b0});
              state         <= S_DIVE;
            end
          end
        end
        S_DIVE: begin
          if (alu_rsp.done) begin
            qtime <= span[TIME_W] ? sat_time(sum_sub) : sat_time(sum_add);
            state <= S_DONE;
          end
        end
        S_RDQ: state <= S_RDQ1;
        S_RDQ1: begin
          bi    <= ram_q;
          state <= S_INTP;
        end
        S_INTP: begin
          neg           <= y[TIME_W+6];
          alu_req.start <= 1'b1;
          alu_req.op    <= ALU_DIV;
          alu_req.a     <= OPA_W'({y_mag, 1'b0}) + OPA_W'(s);
          alu_req.b     <= OPB_W'({s, 1'b0});
          state         <= S_DIVI;
        end
        S_DIVI: begin
          if (alu_rsp.done) begin
            qtime <= neg ? sat_time(SUMT_W'(bi) - SUMT_W'(alu_rsp.quo))
                         : sat_time(SUMT_W'(bi) + SUMT_W'(alu_rsp.quo));
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bgq_ram #(
    .WIDTH(TIME_W),
    .DEPTH(BEATS_MAX)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(item.entry_index)),
    .wdata (item.time_value),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  bgq_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign item.ready            = (state == S_IDLE);
  assign result.valid          = res_valid;
  assign result.quantized_time = res_time;
  assign result.grid_position  = $signed(res_pos);
  assign result.grid_valid     = res_ok;

endmodule
`default_nettype wire
